// ===== rtl/cpo_pkg.sv =====
// Shared types and codes for the convex polygon overlap test core.
// No dependencies; imported by the top level and the projection unit.
package cpo_pkg;

    typedef enum logic [1:0] {
        REQ_VERT_A = 2'd0,
        REQ_VERT_B = 2'd1,
        REQ_EVAL   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // Sample control that travels with each vertex into the projection unit.
    typedef struct packed {
        logic valid;
        logic tag;     // 0: first polygon, 1: second polygon
        logic first;   // first vertex of this polygon on this axis
    } proj_ctl_t;

endpackage

// ===== rtl/cpo_cell.sv =====
// One vertex cell of a rotating vertex chain.
// No dependencies.
module cpo_cell #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         shift_en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] q_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/cpo_chain.sv =====
// Row of vertex cells: loads at the head, rotates the first cnt cells.
// Depends on cpo_cell.
module cpo_chain #(
    parameter int NV   = 16,
    parameter int W    = 32,
    parameter int CNTW = $clog2(NV + 1)
) (
    input  logic            aclk,
    input  logic            load_en,
    input  logic            rot_en,
    input  logic [W-1:0]    din,
    input  logic [CNTW-1:0] cnt,
    output logic [W-1:0]    head0,
    output logic [W-1:0]    head1
);

    localparam int IW = (NV > 1) ? $clog2(NV) : 1;

    logic [W-1:0]    d_arr [NV];
    logic [W-1:0]    q_arr [NV];
    logic [CNTW-1:0] tail_idx;

    assign tail_idx = cnt - CNTW'(1);

    // Head takes a new vertex on load, else the last occupied cell on rotate.
    assign d_arr[0] = load_en ? din : q_arr[tail_idx[IW-1:0]];

    for (genvar k = 0; k < NV; k++) begin : g_cell
        if (k > 0) begin : g_link
            assign d_arr[k] = q_arr[k-1];
        end
        cpo_cell #(.W(W)) u_cell (
            .aclk     (aclk),
            .shift_en (load_en | rot_en),
            .d        (d_arr[k]),
            .q        (q_arr[k])
        );
    end

    assign head0 = q_arr[0];
    assign head1 = q_arr[1];

endmodule

// ===== rtl/cpo_proj.sv =====
// Pipelined projection unit: dot product of a vertex with an axis, then
// running min/max per polygon. Depends on cpo_pkg.
module cpo_proj
    import cpo_pkg::*;
#(
    parameter int CW = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  proj_ctl_t             ctl,
    input  logic signed [CW-1:0]  vx,
    input  logic signed [CW-1:0]  vy,
    input  logic signed [CW:0]    ax,
    input  logic signed [CW:0]    ay,
    output logic                  busy,
    output logic signed [2*CW+1:0] mn_a,
    output logic signed [2*CW+1:0] mx_a,
    output logic signed [2*CW+1:0] mn_b,
    output logic signed [2*CW+1:0] mx_b
);

    localparam int PW = 2 * CW + 1;
    localparam int SW = 2 * CW + 2;

    proj_ctl_t            ctl1_reg, ctl2_reg;
    logic signed [PW-1:0] px_reg, py_reg;
    logic signed [SW-1:0] sum_reg;
    logic signed [SW-1:0] mn_a_reg, mx_a_reg, mn_b_reg, mx_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else begin
            ctl1_reg <= ctl;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg  <= PW'(vx * ax);
        py_reg  <= PW'(vy * ay);
        sum_reg <= SW'(px_reg) + SW'(py_reg);
        if (ctl2_reg.valid) begin
            if (!ctl2_reg.tag) begin
                if (ctl2_reg.first || sum_reg < mn_a_reg) mn_a_reg <= sum_reg;
                if (ctl2_reg.first || sum_reg > mx_a_reg) mx_a_reg <= sum_reg;
            end else begin
                if (ctl2_reg.first || sum_reg < mn_b_reg) mn_b_reg <= sum_reg;
                if (ctl2_reg.first || sum_reg > mx_b_reg) mx_b_reg <= sum_reg;
            end
        end
    end

    assign busy = ctl1_reg.valid | ctl2_reg.valid;
    assign mn_a = mn_a_reg;
    assign mx_a = mx_a_reg;
    assign mn_b = mn_b_reg;
    assign mx_b = mx_b_reg;

endmodule

// ===== rtl/convex_polygon_overlap_test_core.sv =====
// Convex polygon overlap test (2-D separating axis) over two vertex chains.
// An evaluate projects both polygons onto each edge normal in turn, using the single
// projection unit fed one vertex per cycle from the chains.
// Reset (aresetn low, synchronous) empties both polygons and clears the flag.
// Depends on cpo_pkg, cpo_chain, cpo_proj.
module convex_polygon_overlap_test_core
    import cpo_pkg::*;
#(
    parameter int MAX_VERTS  = 16,
    parameter int COORD_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // [1:0] req_type, then vert_x, then vert_y, zero padded to bytes
    input  logic [((2*COORD_BITS+2+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // [0] collide, [1] overflowed, zero padded
    output logic [7:0] m_tdata
);

    localparam int CW   = COORD_BITS;
    localparam int VW   = 2 * CW;
    localparam int CNTW = $clog2(MAX_VERTS + 1);
    localparam int SW   = 2 * CW + 2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_AXIS, ST_PROJ_A, ST_PROJ_B, ST_WAIT, ST_CHECK, ST_OUT
    } state_t;

    state_t              state_reg;
    logic [CNTW-1:0]     cnt_a_reg, cnt_b_reg, edge_reg, vcnt_reg;
    logic                drop_reg, poly_reg, hit_reg;
    logic [1:0]          wait_reg;
    logic signed [CW:0]  ax_reg, ay_reg;
    logic                m_tvalid_reg, m_collide_reg, m_ovf_reg;

    logic                s_acc;
    req_t                req;
    logic [VW-1:0]       din;
    logic                load_a, load_b, rot_a, rot_b;
    logic [VW-1:0]       a_h0, a_h1, b_h0, b_h1;
    logic [VW-1:0]       p_h0, p_h1, p_nxt, feed;
    logic [CNTW-1:0]     p_cnt;
    logic signed [CW:0]  ax_next, ay_next;
    proj_ctl_t           pctl;
    logic                proj_busy;
    logic signed [SW-1:0] mn_a, mx_a, mn_b, mx_b;
    logic                overlap;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign req      = req_t'(s_tdata[1:0]);
    assign din      = s_tdata[VW+1:2];

    assign load_a = s_acc && req == REQ_VERT_A && cnt_a_reg != CNTW'(MAX_VERTS);
    assign load_b = s_acc && req == REQ_VERT_B && cnt_b_reg != CNTW'(MAX_VERTS);
    // Projection rotates a chain once fully; the edge chain also steps once per axis.
    assign rot_a = state_reg == ST_PROJ_A || (state_reg == ST_CHECK && !poly_reg);
    assign rot_b = state_reg == ST_PROJ_B || (state_reg == ST_CHECK && poly_reg);

    cpo_chain #(.NV(MAX_VERTS), .W(VW), .CNTW(CNTW)) u_chain_a (
        .aclk(aclk), .load_en(load_a), .rot_en(rot_a), .din(din),
        .cnt(cnt_a_reg), .head0(a_h0), .head1(a_h1)
    );

    cpo_chain #(.NV(MAX_VERTS), .W(VW), .CNTW(CNTW)) u_chain_b (
        .aclk(aclk), .load_en(load_b), .rot_en(rot_b), .din(din),
        .cnt(cnt_b_reg), .head0(b_h0), .head1(b_h1)
    );

    // Edge from head to its neighbor; a single vertex pairs with itself.
    assign p_h0  = poly_reg ? b_h0 : a_h0;
    assign p_h1  = poly_reg ? b_h1 : a_h1;
    assign p_cnt = poly_reg ? cnt_b_reg : cnt_a_reg;
    assign p_nxt = (p_cnt > CNTW'(1)) ? p_h1 : p_h0;

    assign ax_next = (CW+1)'($signed(p_h0[VW-1:CW])) - (CW+1)'($signed(p_nxt[VW-1:CW]));
    assign ay_next = (CW+1)'($signed(p_nxt[CW-1:0])) - (CW+1)'($signed(p_h0[CW-1:0]));

    assign feed        = (state_reg == ST_PROJ_B) ? b_h0 : a_h0;
    assign pctl.valid  = state_reg == ST_PROJ_A || state_reg == ST_PROJ_B;
    assign pctl.tag    = state_reg == ST_PROJ_B;
    assign pctl.first  = vcnt_reg == '0;

    cpo_proj #(.CW(CW)) u_proj (
        .aclk(aclk), .aresetn(aresetn), .ctl(pctl),
        .vx($signed(feed[CW-1:0])), .vy($signed(feed[VW-1:CW])),
        .ax(ax_reg), .ay(ay_reg), .busy(proj_busy),
        .mn_a(mn_a), .mx_a(mx_a), .mn_b(mn_b), .mx_b(mx_b)
    );

    assign overlap = (mx_b >= mn_a) && (mx_a >= mn_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_a_reg    <= '0;
            cnt_b_reg    <= '0;
            drop_reg     <= 1'b0;
            poly_reg     <= 1'b0;
            edge_reg     <= '0;
            vcnt_reg     <= '0;
            wait_reg     <= '0;
            hit_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        case (req)
                            REQ_VERT_A: begin
                                if (load_a) cnt_a_reg <= cnt_a_reg + CNTW'(1);
                                else        drop_reg  <= 1'b1;
                            end
                            REQ_VERT_B: begin
                                if (load_b) cnt_b_reg <= cnt_b_reg + CNTW'(1);
                                else        drop_reg  <= 1'b1;
                            end
                            REQ_EVAL: begin
                                poly_reg <= 1'b0;
                                edge_reg <= '0;
                                if (cnt_a_reg == '0 || cnt_b_reg == '0) begin
                                    hit_reg   <= cnt_a_reg == '0 && cnt_b_reg == '0;
                                    state_reg <= ST_OUT;
                                end else begin
                                    state_reg <= ST_AXIS;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_AXIS: begin
                    ax_reg   <= ax_next;
                    ay_reg   <= ay_next;
                    vcnt_reg <= '0;
                    if (ax_next == '0 && ay_next == '0) begin
                        hit_reg   <= 1'b0;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_PROJ_A;
                    end
                end
                ST_PROJ_A: begin
                    if (vcnt_reg == cnt_a_reg - CNTW'(1)) begin
                        vcnt_reg  <= '0;
                        state_reg <= ST_PROJ_B;
                    end else begin
                        vcnt_reg <= vcnt_reg + CNTW'(1);
                    end
                end
                ST_PROJ_B: begin
                    if (vcnt_reg == cnt_b_reg - CNTW'(1)) begin
                        wait_reg  <= 2'd2;
                        state_reg <= ST_WAIT;
                    end else begin
                        vcnt_reg <= vcnt_reg + CNTW'(1);
                    end
                end
                ST_WAIT: begin
                    // hold until the last sample has reached min/max
                    wait_reg <= wait_reg - 2'd1;
                    if (wait_reg == 2'd1) state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (!overlap) begin
                        hit_reg   <= 1'b0;
                        state_reg <= ST_OUT;
                    end else if (edge_reg == p_cnt - CNTW'(1)) begin
                        if (!poly_reg) begin
                            poly_reg  <= 1'b1;
                            edge_reg  <= '0;
                            state_reg <= ST_AXIS;
                        end else begin
                            hit_reg   <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                    end else begin
                        edge_reg  <= edge_reg + CNTW'(1);
                        state_reg <= ST_AXIS;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg  <= 1'b1;
                        m_collide_reg <= hit_reg;
                        m_ovf_reg     <= drop_reg;
                        cnt_a_reg     <= '0;
                        cnt_b_reg     <= '0;
                        drop_reg      <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_ovf_reg, m_collide_reg};

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_a_reg <= CNTW'(MAX_VERTS) && cnt_b_reg <= CNTW'(MAX_VERTS))
        else $error("vertex count beyond capacity");

    a_idle_no_feed: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !pctl.valid)
        else $error("projection fed while idle");

    a_check_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CHECK |-> !proj_busy)
        else $error("interval check before projection drained");

    a_clear_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> cnt_a_reg == '0 && cnt_b_reg == '0 && !drop_reg)
        else $error("stores not cleared with result");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for convex_polygon_overlap_test_core: loads polygon pairs,
// evaluates overlap and checks each verdict against a local separating-axis predictor.
// Depends on cpo_pkg and the core RTL.
module tb_top;
    import cpo_pkg::*;

    localparam int NV = 16;
    localparam int CB = 16;
    localparam int DW = ((2*CB+2+7)/8)*8;

    typedef struct packed {
        logic collide;
        logic overflowed;
    } verdict_t;

    typedef struct {
        req_t              req;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic              known;   // expected result typed in
        verdict_t          want;
    } stim_row_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [DW-1:0]  s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [7:0]     m_tdata;

    convex_polygon_overlap_test_core #(.MAX_VERTS(NV), .COORD_BITS(CB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #1 aclk = ~aclk;

    // predictor state
    longint   poly_x[2][NV];
    longint   poly_y[2][NV];
    int       poly_n[2];
    bit       dropped;
    verdict_t verdict_q[$];
    int       errors = 0;

    function automatic bit axis_separates(int p, int i);
        longint ax, ay, d, lo[2], hi[2];
        int j;
        j  = (i + 1 == poly_n[p]) ? 0 : i + 1;
        ax = poly_y[p][i] - poly_y[p][j];
        ay = poly_x[p][j] - poly_x[p][i];
        if (ax == 0 && ay == 0) return 1'b1;
        for (int q = 0; q < 2; q++) begin
            for (int k = 0; k < poly_n[q]; k++) begin
                d = poly_x[q][k] * ax + poly_y[q][k] * ay;
                if (k == 0 || d < lo[q]) lo[q] = d;
                if (k == 0 || d > hi[q]) hi[q] = d;
            end
        end
        return !(hi[1] >= lo[0] && hi[0] >= lo[1]);
    endfunction

    function automatic verdict_t predict_overlap(req_t req, logic signed [15:0] x,
                                                 logic signed [15:0] y);
        verdict_t v;
        bit sep;
        int p;
        v = '0;
        if (req == REQ_VERT_A || req == REQ_VERT_B) begin
            p = (req == REQ_VERT_B);
            if (poly_n[p] < NV) begin
                poly_x[p][poly_n[p]] = x;
                poly_y[p][poly_n[p]] = y;
                poly_n[p]++;
            end else begin
                dropped = 1'b1;
            end
        end else if (req == REQ_EVAL) begin
            if (poly_n[0] == 0 || poly_n[1] == 0) begin
                v.collide = (poly_n[0] == 0 && poly_n[1] == 0);
            end else begin
                sep = 1'b0;
                for (int q = 0; q < 2 && !sep; q++)
                    for (int i = 0; i < poly_n[q] && !sep; i++)
                        sep = axis_separates(q, i);
                v.collide = !sep;
            end
            v.overflowed = dropped;
            poly_n[0] = 0;
            poly_n[1] = 0;
            dropped = 1'b0;
        end
        return v;
    endfunction

    // Valid stays up after a transfer and drops only when the next item idles.
    task automatic send_item(req_t req, logic signed [15:0] x, logic signed [15:0] y,
                             bit known, verdict_t want);
        verdict_t v;
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(DW-34){1'b0}}, y, x, req};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        v = predict_overlap(req, x, y);
        if (req == REQ_EVAL) begin
            if (known && v != want) begin
                $error("directed row disagrees with predictor");
                errors++;
            end
            verdict_q.push_back(known ? want : v);
        end
    endtask

    // drop valid after the last transfer so nothing is sent twice
    task automatic idle_input();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // result side: random stalls, compare against oldest expectation
    initial begin
        verdict_t got, exp_v;
        int stall;
        @(posedge aresetn);
        forever begin
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got = '{collide: m_tdata[0], overflowed: m_tdata[1]};
            if (verdict_q.size() == 0) begin
                $error("result transfer with no expectation pending");
                errors++;
            end else begin
                exp_v = verdict_q.pop_front();
                if (got.collide != exp_v.collide) begin
                    $error("collide: expected %0d actual %0d", exp_v.collide, got.collide);
                    errors++;
                end
                if (got.overflowed != exp_v.overflowed) begin
                    $error("overflowed: expected %0d actual %0d",
                           exp_v.overflowed, got.overflowed);
                    errors++;
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("convex_polygon_overlap_test_core: mismatch");
        $finish;
    end

    task automatic random_polygon(req_t req, int n, int span);
        int cx, cy, r;
        cx = $urandom_range(0, 2*span) - span;
        cy = $urandom_range(0, 2*span) - span;
        r  = $urandom_range(1, span);
        for (int k = 0; k < n; k++) begin
            // vertices on a rough square boundary, counterclockwise corners
            case (k % 4)
                0: send_item(req, 16'(cx - r), 16'(cy - r), 0, '0);
                1: send_item(req, 16'(cx + r), 16'(cy - r), 0, '0);
                2: send_item(req, 16'(cx + r), 16'(cy + r), 0, '0);
                default: send_item(req, 16'(cx - r), 16'(cy + r), 0, '0);
            endcase
        end
    endtask

    stim_row_t rows[$];
    verdict_t  zero_v = '0;

    initial begin
        int items, n, nb, kind;
        bit drained;
        poly_n[0] = 0; poly_n[1] = 0; dropped = 0;
        drained = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty pair, one empty, extremes, degenerate, overflow
        rows = '{
            '{REQ_EVAL,   0, 0, 1, '{1'b1, 1'b0}},
            '{REQ_VERT_A, 0, 0, 1, zero_v},
            '{REQ_EVAL,   0, 0, 1, '{1'b0, 1'b0}},
            '{REQ_NONE,  -1, -1, 0, zero_v},
            '{REQ_VERT_A, -32768, -32768, 0, zero_v},
            '{REQ_VERT_A,  32767, -32768, 0, zero_v},
            '{REQ_VERT_A,  32767,  32767, 0, zero_v},
            '{REQ_VERT_B,      0,      0, 0, zero_v},
            '{REQ_VERT_B,    100,      0, 0, zero_v},
            '{REQ_VERT_B,      0,    100, 0, zero_v},
            '{REQ_EVAL,   0, 0, 0, zero_v},
            '{REQ_VERT_A, 5, 5, 0, zero_v},
            '{REQ_VERT_B, 5, 5, 0, zero_v},
            '{REQ_EVAL,  -1, -1, 1, '{1'b0, 1'b0}},
            '{REQ_VERT_B, 7, 7, 0, zero_v},
            '{REQ_EVAL,   0, 0, 1, '{1'b0, 1'b0}}
        };
        foreach (rows[i]) send_item(rows[i].req, rows[i].x, rows[i].y,
                                    rows[i].known, rows[i].want);
        // overflow: seventeen vertices into the first polygon
        for (int k = 0; k < NV + 1; k++) send_item(REQ_VERT_A, 16'(k), 16'(k*k), 0, '0);
        send_item(REQ_VERT_B, 1, 1, 0, '0);
        send_item(REQ_EVAL, 0, 0, 0, '0);

        items = 0;
        while (items < 1100) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                n = $urandom_range(0, 9) == 0 ? $urandom_range(1, NV + 2)
                                              : $urandom_range(1, 5);
                nb = $urandom_range(1, 5);
                random_polygon(REQ_VERT_A, n, kind < 3 ? 40 : 30000);
                random_polygon(REQ_VERT_B, nb, kind < 3 ? 40 : 30000);
                items += n + nb;
            end else begin
                // noise: arbitrary vertices and unused codes
                repeat ($urandom_range(1, 6)) begin
                    send_item(req_t'($urandom_range(0, 3)), 16'($urandom),
                              16'($urandom), 0, '0);
                    items++;
                end
            end
            send_item(REQ_EVAL, 16'($urandom), 16'($urandom), 0, '0);
            items++;
            if (!drained && items > 500) begin
                idle_input();
                while (verdict_q.size() != 0) @(posedge aclk);
                drained = 1'b1;
            end
        end

        idle_input();
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0)
            $display("convex_polygon_overlap_test_core: match");
        else
            $display("convex_polygon_overlap_test_core: mismatch");
        $finish;
    end
endmodule
